// File: rtl/core/csl_pkg.sv
// csl_pkg: token types, token codes and character tables for the C source lexer.
// Used by csl_front, csl_queue, csl_back and the top level. No dependencies.
package csl_pkg;

  // token classes
  localparam logic [1:0] CLS_KW  = 2'd0;
  localparam logic [1:0] CLS_ID  = 2'd1;
  localparam logic [1:0] CLS_LIT = 2'd2;
  localparam logic [1:0] CLS_SEP = 2'd3;

  // literal subtypes
  localparam logic [5:0] LIT_HEX    = 6'd0;
  localparam logic [5:0] LIT_OCT    = 6'd1;
  localparam logic [5:0] LIT_U      = 6'd2;
  localparam logic [5:0] LIT_L      = 6'd3;
  localparam logic [5:0] LIT_DEC    = 6'd4;
  localparam logic [5:0] LIT_FLOAT  = 6'd5;
  localparam logic [5:0] LIT_FLOATF = 6'd6;
  localparam logic [5:0] LIT_FLOATL = 6'd7;
  localparam logic [5:0] LIT_STRING = 6'd8;
  localparam logic [5:0] LIT_CHAR   = 6'd9;

  // separator codes
  localparam logic [5:0] SEP_TRIPLE_DOT = 6'd0;
  localparam logic [5:0] SEP_SINGLE     = 6'd19;
  localparam logic [5:0] SEP_DOT        = 6'd25;
  localparam logic [5:0] SGL_NONE       = 6'd63;
  localparam logic [4:0] MUL_NONE       = 5'd31;

  localparam int NKW = 44;
  localparam int NSINGLE = 25;
  localparam int QDEPTH = 4;

  // number flag bits
  localparam int NF_FLOAT = 0;
  localparam int NF_U     = 1;
  localparam int NF_L     = 2;
  localparam int NF_ZERO  = 3;
  localparam int NF_HEX   = 4;

  // keyword text, right aligned, and lengths
  localparam logic [119:0] KW_TEXT [NKW] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if",
    "inline", "int", "long", "register", "restrict", "return", "short",
    "signed", "sizeof", "static", "struct", "switch", "typedef", "union",
    "unsigned", "void", "volatile", "while", "_Alignas", "_Alignof",
    "_Atomic", "_Bool", "_Complex", "_Generic", "_Imaginary", "_Noreturn",
    {"_Static", "_assert"}, {"_Thread", "_local"}
  };
  localparam logic [3:0] KW_LEN [NKW] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
    4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
    4'd6, 4'd3, 4'd4, 4'd8, 4'd8, 4'd6, 4'd5,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd5,
    4'd8, 4'd4, 4'd8, 4'd5, 4'd8, 4'd8,
    4'd7, 4'd5, 4'd8, 4'd8, 4'd10, 4'd9,
    4'd14, 4'd13
  };
  localparam logic [8*NSINGLE-1:0] SINGLE_OPS = "(){}[].+-*/%^&|~!=<>?:;,#";

  typedef struct packed {
    logic [15:0] pos;
    logic [5:0]  code;
    logic [1:0]  cls;
  } token_t;

  // queue entry: one or two tokens from one item
  typedef struct packed {
    logic   two;
    token_t t1;
    token_t t0;
  } qent_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // index into the single-character operator list, SGL_NONE if absent
  function automatic logic [5:0] sgl_idx(input logic [7:0] c);
    logic [5:0] r;
    r = SGL_NONE;
    for (int i = NSINGLE - 1; i >= 0; i--) begin
      if (SINGLE_OPS[8*(NSINGLE-1-i) +: 8] == c) r = 6'(i);
    end
    return r;
  endfunction

  // two-character operator index, MUL_NONE if none
  function automatic logic [4:0] mul_idx(input logic [7:0] h, input logic [7:0] c);
    logic [4:0] r;
    r = MUL_NONE;
    unique case ({h, c})
      {"-", ">"}: r = 5'd1;
      {"+", "+"}: r = 5'd2;
      {"-", "-"}: r = 5'd3;
      {"+", "="}: r = 5'd4;
      {"-", "="}: r = 5'd5;
      {"*", "="}: r = 5'd6;
      {"/", "="}: r = 5'd7;
      {"%", "="}: r = 5'd8;
      {"&", "="}: r = 5'd9;
      {"|", "="}: r = 5'd10;
      {"^", "="}: r = 5'd11;
      {"=", "="}: r = 5'd12;
      {"!", "="}: r = 5'd13;
      {"<", "="}: r = 5'd14;
      {">", "="}: r = 5'd15;
      {"&", "&"}: r = 5'd16;
      {"|", "|"}: r = 5'd17;
      {"#", "#"}: r = 5'd18;
      default: r = MUL_NONE;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/csl_front.sv
// csl_front: scanner state machine; takes one byte per cycle while the queue has
// room and produces the zero, one or two tokens it completes. Depends on csl_pkg.
module csl_front #(
  parameter int MAX_SOURCE_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              in_end,
  input  logic              q_ready,
  output logic              q_push,
  output csl_pkg::qent_t    q_data
);

  localparam int POS_W = $clog2(MAX_SOURCE_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_SOURCE_BYTES - 1);

  typedef enum logic [8:0] {
    M_IDLE  = 9'b000000001,
    M_LINE  = 9'b000000010,
    M_BLOCK = 9'b000000100,
    M_BSTAR = 9'b000001000,
    M_IDENT = 9'b000010000,
    M_NUM   = 9'b000100000,
    M_QUOTE = 9'b001000000,
    M_ESC   = 9'b010000000,
    M_OPER  = 9'b100000000
  } mode_t;

  mode_t                   mode, mode_next;
  logic [POS_W-1:0]        bpos, bpos_next;
  logic [POS_W-1:0]        tstart, tstart_next;
  logic [15:0]             run_len, run_len_next;
  logic [csl_pkg::NKW-1:0] kw, kw_next;
  logic [4:0]              nflags, nflags_next;
  logic [7:0]              fchar, fchar_next;
  logic [7:0]              held0, held0_next;
  logic [1:0]              held_cnt, held_cnt_next;
  logic                    qdbl, qdbl_next;

  logic                    accept;
  logic [1:0]              e_n;
  csl_pkg::token_t         e0, e1;
  logic [csl_pkg::NKW-1:0] kw_filt, kw_first;
  csl_pkg::token_t         tok_id, tok_num, tok_quote, tok_single, tok_dot0, tok_dot1;
  logic [15:0]             pos16, start16;
  logic [POS_W-1:0]        start_inc;
  logic [5:0]              c_sgl, h_sgl;
  logic [4:0]              c_mul;
  logic                    do_begin;

  assign accept = in_valid && q_ready;
  assign start16 = 16'(tstart);
  assign pos16 = 16'(bpos);
  assign start_inc = (tstart == POS_LAST) ? '0 : tstart + 1'b1;
  assign c_sgl = csl_pkg::sgl_idx(in_byte);
  assign h_sgl = csl_pkg::sgl_idx(held0);
  assign c_mul = csl_pkg::mul_idx(held0, in_byte);

  // keyword filters: continuing run and first character
  always_comb begin
    logic [3:0] off;
    for (int k = 0; k < csl_pkg::NKW; k++) begin
      kw_filt[k] = 1'b0;
      if (run_len < 16'd15 && run_len[3:0] < csl_pkg::KW_LEN[k]) begin
        off = csl_pkg::KW_LEN[k] - 4'd1 - run_len[3:0];
        kw_filt[k] = kw[k] && (csl_pkg::KW_TEXT[k][8*off +: 8] == in_byte);
      end
      off = csl_pkg::KW_LEN[k] - 4'd1;
      kw_first[k] = csl_pkg::KW_TEXT[k][8*off +: 8] == in_byte;
    end
  end

  // pending tokens as they would flush now
  always_comb begin
    logic found;
    found = 1'b0;
    tok_id = '{pos: start16, code: 6'd0, cls: csl_pkg::CLS_ID};
    for (int k = 0; k < csl_pkg::NKW; k++) begin
      if (!found && kw[k] && run_len == 16'(csl_pkg::KW_LEN[k])) begin
        found = 1'b1;
        tok_id.cls = csl_pkg::CLS_KW;
        tok_id.code = 6'(k);
      end
    end
    tok_num = '{pos: start16, code: csl_pkg::LIT_DEC, cls: csl_pkg::CLS_LIT};
    if (nflags[csl_pkg::NF_FLOAT]) begin
      if (fchar == "f" || fchar == "F") tok_num.code = csl_pkg::LIT_FLOATF;
      else if (fchar == "l" || fchar == "L") tok_num.code = csl_pkg::LIT_FLOATL;
      else tok_num.code = csl_pkg::LIT_FLOAT;
    end else if (nflags[csl_pkg::NF_HEX]) tok_num.code = csl_pkg::LIT_HEX;
    else if (nflags[csl_pkg::NF_ZERO] && run_len > 16'd1) tok_num.code = csl_pkg::LIT_OCT;
    else if (nflags[csl_pkg::NF_U]) tok_num.code = csl_pkg::LIT_U;
    else if (nflags[csl_pkg::NF_L]) tok_num.code = csl_pkg::LIT_L;
    tok_quote = '{pos: start16, code: qdbl ? csl_pkg::LIT_STRING : csl_pkg::LIT_CHAR,
                  cls: csl_pkg::CLS_LIT};
    tok_single = '{pos: start16, code: csl_pkg::SEP_SINGLE + h_sgl, cls: csl_pkg::CLS_SEP};
    tok_dot0 = '{pos: start16, code: csl_pkg::SEP_DOT, cls: csl_pkg::CLS_SEP};
    tok_dot1 = '{pos: 16'(start_inc), code: csl_pkg::SEP_DOT, cls: csl_pkg::CLS_SEP};
  end

  // next state and emitted tokens
  always_comb begin
    mode_next = mode;
    bpos_next = bpos;
    tstart_next = tstart;
    run_len_next = run_len;
    kw_next = kw;
    nflags_next = nflags;
    fchar_next = fchar;
    held0_next = held0;
    held_cnt_next = held_cnt;
    qdbl_next = qdbl;
    e_n = 2'd0;
    e0 = tok_id;
    e1 = tok_dot1;
    do_begin = 1'b0;

    if (in_end) begin
      // flush and return to reset state
      unique case (mode)
        M_IDENT: begin e_n = 2'd1; e0 = tok_id; end
        M_NUM: begin e_n = 2'd1; e0 = tok_num; end
        M_QUOTE, M_ESC: begin e_n = 2'd1; e0 = tok_quote; end
        M_OPER: begin
          if (held_cnt == 2'd2) begin
            e_n = 2'd2; e0 = tok_dot0;
          end else if (held_cnt == 2'd1 && h_sgl != csl_pkg::SGL_NONE) begin
            e_n = 2'd1; e0 = tok_single;
          end
        end
        M_IDLE, M_LINE, M_BLOCK, M_BSTAR: ;
        default: ;
      endcase
      mode_next = M_IDLE;
      bpos_next = '0;
      tstart_next = '0;
      run_len_next = '0;
      kw_next = '1;
      nflags_next = '0;
      fchar_next = '0;
      held_cnt_next = '0;
      qdbl_next = 1'b0;
    end else begin
      bpos_next = (bpos == POS_LAST) ? '0 : bpos + 1'b1;
      unique case (mode)
        M_LINE: if (in_byte == 8'h0A) mode_next = M_IDLE;
        M_BLOCK: if (in_byte == "*") mode_next = M_BSTAR;
        M_BSTAR: begin
          if (in_byte == "/") mode_next = M_IDLE;
          else if (in_byte != "*") mode_next = M_BLOCK;
        end
        M_QUOTE: begin
          if (in_byte == "\\") mode_next = M_ESC;
          else if (in_byte == (qdbl ? 8'h22 : 8'h27)) begin
            e_n = 2'd1; e0 = tok_quote; mode_next = M_IDLE;
          end
        end
        M_ESC: mode_next = M_QUOTE;
        M_IDENT: begin
          if (csl_pkg::is_alpha(in_byte) || csl_pkg::is_digit(in_byte) || in_byte == "_")
          begin
            kw_next = kw_filt;
            if (run_len != 16'hFFFF) run_len_next = run_len + 16'd1;
          end else begin
            e_n = 2'd1; e0 = tok_id; do_begin = 1'b1;
          end
        end
        M_NUM: begin
          if (csl_pkg::is_alpha(in_byte) || csl_pkg::is_digit(in_byte) || in_byte == ".")
          begin
            if (run_len == 16'd1 && nflags[csl_pkg::NF_ZERO] &&
                (in_byte == "x" || in_byte == "X")) nflags_next[csl_pkg::NF_HEX] = 1'b1;
            if (in_byte == ".") nflags_next[csl_pkg::NF_FLOAT] = 1'b1;
            if ((in_byte == "e" || in_byte == "E") && !nflags[csl_pkg::NF_HEX])
              nflags_next[csl_pkg::NF_FLOAT] = 1'b1;
            if (in_byte == "u" || in_byte == "U") nflags_next[csl_pkg::NF_U] = 1'b1;
            if (in_byte == "l" || in_byte == "L") nflags_next[csl_pkg::NF_L] = 1'b1;
            fchar_next = in_byte;
            if (run_len != 16'hFFFF) run_len_next = run_len + 16'd1;
          end else begin
            e_n = 2'd1; e0 = tok_num; do_begin = 1'b1;
          end
        end
        M_OPER: begin
          if (held_cnt == 2'd2) begin
            if (in_byte == ".") begin
              e_n = 2'd1;
              e0 = '{pos: start16, code: csl_pkg::SEP_TRIPLE_DOT, cls: csl_pkg::CLS_SEP};
              held_cnt_next = 2'd0; mode_next = M_IDLE;
            end else begin
              e_n = 2'd2; e0 = tok_dot0; held_cnt_next = 2'd0; do_begin = 1'b1;
            end
          end else if (held0 == "/" && in_byte == "/") begin
            held_cnt_next = 2'd0; mode_next = M_LINE;
          end else if (held0 == "/" && in_byte == "*") begin
            held_cnt_next = 2'd0; mode_next = M_BLOCK;
          end else if (held0 == "." && in_byte == ".") begin
            held_cnt_next = 2'd2;
          end else if (c_mul != csl_pkg::MUL_NONE) begin
            e_n = 2'd1;
            e0 = '{pos: start16, code: 6'(c_mul), cls: csl_pkg::CLS_SEP};
            held_cnt_next = 2'd0; mode_next = M_IDLE;
          end else begin
            if (h_sgl != csl_pkg::SGL_NONE) begin e_n = 2'd1; e0 = tok_single; end
            held_cnt_next = 2'd0; do_begin = 1'b1;
          end
        end
        M_IDLE: do_begin = 1'b1;
        default: do_begin = 1'b1;
      endcase

      // start of a new token at this byte
      if (do_begin) begin
        mode_next = M_IDLE;
        if (csl_pkg::is_space(in_byte)) begin
          mode_next = M_IDLE;
        end else if (csl_pkg::is_alpha(in_byte) || in_byte == "_") begin
          mode_next = M_IDENT; tstart_next = bpos; kw_next = kw_first; run_len_next = 16'd1;
        end else if (csl_pkg::is_digit(in_byte)) begin
          mode_next = M_NUM; tstart_next = bpos; run_len_next = 16'd1; fchar_next = in_byte;
          nflags_next = (in_byte == "0") ? 5'(1 << csl_pkg::NF_ZERO) : 5'd0;
        end else if (in_byte == 8'h22 || in_byte == 8'h27) begin
          mode_next = M_QUOTE; tstart_next = bpos; qdbl_next = (in_byte == 8'h22);
        end else if (c_sgl != csl_pkg::SGL_NONE) begin
          mode_next = M_OPER; tstart_next = bpos; held0_next = in_byte; held_cnt_next = 2'd1;
        end
      end
    end
  end

  assign q_push = accept && (e_n != 2'd0);
  assign q_data = '{two: e_n == 2'd2, t1: e1, t0: e0};

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      bpos <= '0;
      tstart <= '0;
      run_len <= '0;
      kw <= '1;
      nflags <= '0;
      fchar <= '0;
      held_cnt <= '0;
      qdbl <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      bpos <= bpos_next;
      tstart <= tstart_next;
      run_len <= run_len_next;
      kw <= kw_next;
      nflags <= nflags_next;
      fchar <= fchar_next;
      held_cnt <= held_cnt_next;
      qdbl <= qdbl_next;
    end
  end

  // held operator character, written before it is read
  always_ff @(posedge clk) begin
    if (accept) held0 <= held0_next;
  end

endmodule

// File: rtl/core/csl_queue.sv
// csl_queue: short FIFO of token entries between scanner and output stage.
// Depends on csl_pkg.
module csl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  csl_pkg::qent_t push_data,
  output logic           not_full,
  input  logic           pop,
  output logic           not_empty,
  output csl_pkg::qent_t head
);

  localparam int PW = $clog2(csl_pkg::QDEPTH);

  csl_pkg::qent_t mem [csl_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [PW:0]    count;

  assign not_full = count != (PW+1)'(csl_pkg::QDEPTH);
  assign not_empty = count != '0;
  assign head = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// File: rtl/core/csl_back.sv
// csl_back: splits queue entries into single tokens into a registered output.
// Depends on csl_pkg.
module csl_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  csl_pkg::qent_t  q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output csl_pkg::token_t out_token,
  output logic            out_last
);

  logic sub;
  logic load, tok_last;

  assign load = !out_valid || out_ready;
  assign tok_last = !q_head.two || sub;
  assign q_pop = load && q_valid && tok_last;

  // output register and token select
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub <= 1'b0;
    end else if (load) begin
      out_valid <= q_valid;
      if (q_valid) sub <= !tok_last;
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      out_token <= sub ? q_head.t1 : q_head.t0;
      out_last <= tok_last;
    end
  end

endmodule

// File: rtl/core/c_source_lexer_top.sv
// c_source_lexer_top: C source lexer, scanner front, token queue, output back.
// Depends on csl_pkg, csl_front, csl_queue, csl_back.
//
// channel  dir  tdata                           tuser       tlast
// s_axis   in   source_byte[7:0]                end_marker  -
// m_axis   out  class[1:0] code[7:2] pos[23:8]  -           last_of_run
//
// One byte is taken per cycle while the queue has room; the scanner state updates in that cycle.
// Output is one token per cycle while m_axis_tready is high, so an item that closes two tokens
// is sent as two output items; the 4-entry queue absorbs that and output stalls.
// A completed token is written into the queue and then into the output register before it appears.
// Reset (rst, synchronous) returns the scanner to idle at position zero.
module c_source_lexer_top #(
  parameter int MAX_SOURCE_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // source_byte[7:0]
  input  logic        s_axis_tuser,   // end_marker
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // token_class[1:0], token_code[7:2], start_pos[23:8]
  output logic        m_axis_tlast
);

  logic            q_push, q_not_full, q_pop, q_not_empty;
  csl_pkg::qent_t  q_in, q_head;
  csl_pkg::token_t out_token;

  assign s_axis_tready = q_not_full;
  assign m_axis_tdata = out_token;

  csl_front #(.MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_byte(s_axis_tdata), .in_end(s_axis_tuser),
    .q_ready(q_not_full), .q_push(q_push), .q_data(q_in)
  );

  csl_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(q_in), .not_full(q_not_full),
    .pop(q_pop), .not_empty(q_not_empty), .head(q_head)
  );

  csl_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_not_empty), .q_head(q_head), .q_pop(q_pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_token(out_token), .out_last(m_axis_tlast)
  );

endmodule

// File: rtl/core/csl_checker.sv
// csl_checker: port-level assertions for the C source lexer, bound to the top.
// Depends on c_source_lexer_top ports and csl_pkg codes.
module csl_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // nothing is offered right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // literal subtypes stay in range
  a_lit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] == csl_pkg::CLS_LIT |->
      m_axis_tdata[7:2] <= csl_pkg::LIT_CHAR)
    else $error("bad literal subtype");

  // identifiers carry code zero
  a_id: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] == csl_pkg::CLS_ID |-> m_axis_tdata[7:2] == 6'd0)
    else $error("identifier with nonzero code");

endmodule

bind c_source_lexer_top csl_checker u_csl_checker (
  .clk(clk), .rst(rst),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

// File: tb/c_source_lexer_top_test.sv
// c_source_lexer_top_test: self-checking bench for the C source lexer top level.
// Depends on csl_pkg and c_source_lexer_top; drives byte items and checks token items.
module c_source_lexer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    SC_IDLE, SC_LINE, SC_BLOCK, SC_BSTAR, SC_IDENT, SC_NUM, SC_QUOTE, SC_ESC, SC_OPER
  } scan_t;

  typedef struct {
    logic [1:0]  cls;
    logic [5:0]  code;
    logic [15:0] pos;
    logic        last;
  } exp_token_t;

  // token predictor and store of expected tokens
  class token_sb_t;
    exp_token_t want_q[$];
    exp_token_t step_q[$];
    int     n_bad;
    int     n_tokens;
    string  kwords[csl_pkg::NKW];
    string  multis[19];
    string  singles;
    scan_t       mode;
    logic [15:0] cur_pos, tok_start, run_len;
    logic [csl_pkg::NKW-1:0] kw_mask;
    logic        f_float, f_u, f_l, f_zero, f_hex;
    logic [7:0]  last_num_ch, held_ch;
    int          held_n;
    logic        dbl_quote;

    function new();
      kwords = '{"auto", "break", "case", "char", "const", "continue", "default", "do",
        "double", "else", "enum", "extern", "float", "for", "goto", "if",
        "inline", "int", "long", "register", "restrict", "return", "short",
        "signed", "sizeof", "static", "struct", "switch", "typedef", "union",
        "unsigned", "void", "volatile", "while", "_Alignas", "_Alignof",
        "_Atomic", "_Bool", "_Complex", "_Generic", "_Imaginary", "_Noreturn",
        string'({"_Static", "_assert"}), string'({"_Thread", "_local"})};
      multis = '{"...", "->", "++", "--", "+=", "-=", "*=", "/=", "%=", "&=", "|=",
        "^=", "==", "!=", "<=", ">=", "&&", "||", "##"};
      singles = "(){}[].+-*/%^&|~!=<>?:;,#";
      clear_state();
    endfunction

    function void clear_state();
      mode = SC_IDLE; cur_pos = 0; tok_start = 0; run_len = 0; kw_mask = '1;
      {f_float, f_u, f_l, f_zero, f_hex} = '0;
      last_num_ch = 0; held_ch = 0; held_n = 0; dbl_quote = 0;
    endfunction

    function void emit(logic [1:0] cls, logic [5:0] code, logic [15:0] p);
      exp_token_t t;
      if (step_q.size() >= 2) return;
      t.cls = cls; t.code = code; t.pos = p; t.last = 0;
      step_q.push_back(t);
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function bit is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function int single_of(logic [7:0] c);
      for (int i = 0; i < singles.len(); i++) if (singles[i] == c) return i;
      return -1;
    endfunction

    function logic [csl_pkg::NKW-1:0] narrow(logic [csl_pkg::NKW-1:0] m, int idx,
                                             logic [7:0] c);
      for (int k = 0; k < csl_pkg::NKW; k++)
        if (m[k] && (idx >= 15 || c == 0 || kwords[k][idx] != c)) m[k] = 1'b0;
      return m;
    endfunction

    function void close_ident();
      for (int k = 0; k < csl_pkg::NKW; k++)
        if (kw_mask[k] && run_len < 15 && kwords[k].len() == run_len) begin
          emit(csl_pkg::CLS_KW, 6'(k), tok_start);
          return;
        end
      emit(csl_pkg::CLS_ID, 6'd0, tok_start);
    endfunction

    function void close_number();
      logic [5:0] code;
      if (f_float) begin
        if (last_num_ch == "f" || last_num_ch == "F") code = csl_pkg::LIT_FLOATF;
        else if (last_num_ch == "l" || last_num_ch == "L") code = csl_pkg::LIT_FLOATL;
        else code = csl_pkg::LIT_FLOAT;
      end else if (f_hex) code = csl_pkg::LIT_HEX;
      else if (f_zero && run_len > 1) code = csl_pkg::LIT_OCT;
      else if (f_u) code = csl_pkg::LIT_U;
      else if (f_l) code = csl_pkg::LIT_L;
      else code = csl_pkg::LIT_DEC;
      emit(csl_pkg::CLS_LIT, code, tok_start);
    endfunction

    function void close_held();
      int s;
      if (held_n == 1) begin
        s = single_of(held_ch);
        if (s >= 0) emit(csl_pkg::CLS_SEP, csl_pkg::SEP_SINGLE + 6'(s), tok_start);
      end else if (held_n == 2) begin
        emit(csl_pkg::CLS_SEP, csl_pkg::SEP_DOT, tok_start);
        emit(csl_pkg::CLS_SEP, csl_pkg::SEP_DOT, tok_start + 16'd1);
      end
      held_n = 0;
    endfunction

    function void start_token(logic [7:0] c, logic [15:0] p);
      mode = SC_IDLE;
      if (c == " " || (c >= 9 && c <= 13)) return;
      if (is_alpha(c) || c == "_") begin
        mode = SC_IDENT; tok_start = p; run_len = 1;
        kw_mask = narrow('1, 0, c);
      end else if (is_num(c)) begin
        mode = SC_NUM; tok_start = p; run_len = 1; last_num_ch = c;
        {f_float, f_u, f_l, f_zero, f_hex} = '0;
        f_zero = (c == "0");
      end else if (c == "\"" || c == "'") begin
        mode = SC_QUOTE; tok_start = p; dbl_quote = (c == "\"");
      end else if (single_of(c) >= 0) begin
        mode = SC_OPER; tok_start = p; held_ch = c; held_n = 1;
      end
    endfunction

    function void oper_byte(logic [7:0] c, logic [15:0] p);
      if (held_n == 2) begin
        if (c == ".") begin
          emit(csl_pkg::CLS_SEP, csl_pkg::SEP_TRIPLE_DOT, tok_start);
          held_n = 0; mode = SC_IDLE;
          return;
        end
        close_held(); start_token(c, p);
        return;
      end
      if (held_ch == "/" && c == "/") begin held_n = 0; mode = SC_LINE; return; end
      if (held_ch == "/" && c == "*") begin held_n = 0; mode = SC_BLOCK; return; end
      if (held_ch == "." && c == ".") begin held_n = 2; return; end
      for (int i = 1; i < 19; i++)
        if (multis[i][0] == held_ch && multis[i][1] == c) begin
          emit(csl_pkg::CLS_SEP, 6'(i), tok_start);
          held_n = 0; mode = SC_IDLE;
          return;
        end
      close_held(); start_token(c, p);
    endfunction

    // work out the tokens caused by one accepted byte item
    function void note_input(logic [7:0] c, logic endm);
      step_q.delete();
      if (endm) begin
        unique case (mode)
          SC_IDENT: close_ident();
          SC_NUM: close_number();
          SC_QUOTE, SC_ESC:
            emit(csl_pkg::CLS_LIT, dbl_quote ? csl_pkg::LIT_STRING : csl_pkg::LIT_CHAR,
                 tok_start);
          SC_OPER: close_held();
          default: ;
        endcase
        clear_state();
      end else begin
        unique case (mode)
          SC_LINE: if (c == "\n") mode = SC_IDLE;
          SC_BLOCK: if (c == "*") mode = SC_BSTAR;
          SC_BSTAR: begin
            if (c == "/") mode = SC_IDLE;
            else if (c != "*") mode = SC_BLOCK;
          end
          SC_QUOTE: begin
            if (c == "\\") mode = SC_ESC;
            else if (c == (dbl_quote ? "\"" : "'")) begin
              emit(csl_pkg::CLS_LIT, dbl_quote ? csl_pkg::LIT_STRING : csl_pkg::LIT_CHAR,
                   tok_start);
              mode = SC_IDLE;
            end
          end
          SC_ESC: mode = SC_QUOTE;
          SC_IDENT: begin
            if (is_alpha(c) || is_num(c) || c == "_") begin
              kw_mask = narrow(kw_mask, run_len, c);
              if (run_len != 16'hFFFF) run_len++;
            end else begin
              close_ident(); start_token(c, cur_pos);
            end
          end
          SC_NUM: begin
            if (is_alpha(c) || is_num(c) || c == ".") begin
              if (run_len == 1 && f_zero && (c == "x" || c == "X")) f_hex = 1;
              if (c == ".") f_float = 1;
              if ((c == "e" || c == "E") && !f_hex) f_float = 1;
              if (c == "u" || c == "U") f_u = 1;
              if (c == "l" || c == "L") f_l = 1;
              last_num_ch = c;
              if (run_len != 16'hFFFF) run_len++;
            end else begin
              close_number(); start_token(c, cur_pos);
            end
          end
          SC_OPER: oper_byte(c, cur_pos);
          default: start_token(c, cur_pos);
        endcase
        cur_pos++;
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1;
      foreach (step_q[i]) want_q.push_back(step_q[i]);
    endfunction

    // compare one accepted token item with the oldest expectation
    function void check_token(logic [23:0] data, logic last);
      exp_token_t w;
      n_tokens++;
      if (want_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected token: data=%h last=%b", data, last);
        return;
      end
      w = want_q.pop_front();
      if (data[1:0] !== w.cls || data[7:2] !== w.code || data[23:8] !== w.pos ||
          last !== w.last) begin
        n_bad++;
        if (n_bad <= 10)
          $display({"token mismatch: exp cls=%0d code=%0d pos=%0d last=%b, ",
                    "got cls=%0d code=%0d pos=%0d last=%b"},
                   w.cls, w.code, w.pos, w.last, data[1:0], data[7:2], data[23:8], last);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  token_sb_t sb = new();
  bit tx_calm = 0;
  bit rx_calm = 0;
  int n_sent = 0;
  int n_ends = 0;
  int stuck = 0;
  localparam int STUCK_LIMIT = 4000;

  c_source_lexer_top i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stuck <= 0;
      else stuck <= stuck + 1;
      if (stuck >= STUCK_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", stuck);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // token receiver with random stalls
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (($urandom % 30) == 0) rx_calm = !rx_calm;
      gap = rx_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      sb.check_token(m_axis_tdata, m_axis_tlast);
    end
  end

  task automatic send_byte(logic [7:0] c, logic endm);
    int gap;
    if (($urandom % 40) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= c;
    s_axis_tuser <= endm;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_input(c, endm);
    n_sent++;
    if (endm) n_ends++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_byte(8'($urandom), 1'b1);
  endtask

  // random C-like fragments: mostly well-formed tokens, some noise and end items
  task automatic send_random(int n_items);
    string words[] = '{"x1", "_foo", "autox", "in", "whilee", "Z9_",
      "0x1E", "0755", "0", "12u", "34L", "1.5", "2.5f", "3e8L", "0x.1", "1e+5", "09", "7UL",
      "\"ab\\\"c\"", "'\\n'", "'a'", "\"l1\nl2\"", "/* c ** */", "// line\n",
      "...", "..", "->", "++", "--", "+=", "-=", "*=", "/=", "%=", "&=", "|=", "^=",
      "==", "!=", "<=", ">=", "&&", "||", "##",
      "( ) { } [ ] . + - * / % ^ & | ~ ! = < > ? : ; , #"};
    string seps[] = '{"", " ", "\n", "\t", "  "};
    int start_n;
    int r;
    start_n = n_sent;
    while (n_sent - start_n < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 6) send_byte(8'($urandom), 1'b0);
      else if (r < 9) send_end();
      else if (r < 40) send_text(sb.kwords[$urandom_range(0, csl_pkg::NKW - 1)]);
      else send_text(words[$urandom_range(0, words.size() - 1)]);
      send_text(seps[$urandom_range(0, seps.size() - 1)]);
    end
    send_end();
  endtask

  initial begin
    int tail;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: hex with e, exponent sign, two dots, comments, escapes, unknown bytes
    send_text("0x1e+1.f a..b/**/");
    send_end();
    send_text("'\\");
    send_end();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("$->\"x");
    send_end();
    send_random(520);
    s_axis_tvalid <= 0;
    while (sb.want_q.size() > 0) @(posedge clk);
    tail = 0;
    while (tail < 30) begin
      @(posedge clk);
      tail++;
    end
    $display("sent %0d byte items with %0d end items, checked %0d tokens",
             n_sent, n_ends, sb.n_tokens);
    $display("directed corner cases plus random C fragments under random stalls");
    if (sb.n_bad == 0 && sb.want_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d tokens missing", sb.n_bad, sb.want_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// File: c_source_lexer_top.f
rtl/core/csl_pkg.sv
rtl/core/csl_front.sv
rtl/core/csl_queue.sv
rtl/core/csl_back.sv
rtl/core/c_source_lexer_top.sv
rtl/core/csl_checker.sv
tb/c_source_lexer_top_test.sv
